// ===== src/pva_pkg.sv =====
// shared types and constants for the priority voice allocator
`timescale 1ns / 1ps
`default_nettype none

package pva_pkg;

  // field widths
  localparam int unsigned FUNC_W      = 3;
  localparam int unsigned GROUP_W     = 4;
  localparam int unsigned PRI_W       = 7;
  localparam int unsigned VOICE_W     = 6;
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned CFG_W       = 48;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned NUM_CFG     = 4;
  localparam int unsigned RANGE_FLD_W = 12;

  // reset value of every range word: min 0, max 47 for each group
  localparam logic [CFG_W-1:0] RANGE_RESET = 48'hBC0BC0BC0BC0;

  // priorities at or above this can never be stolen
  localparam logic [PRI_W-1:0] PRIO_LOCKED = 7'h7E;

  // request operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC       = 3'd0,
    FUNC_ALLOC_EXT   = 3'd1,
    FUNC_ALLOC_NOISE = 3'd2,
    FUNC_FREE        = 3'd3,
    FUNC_PLAY        = 3'd4
  } func_e;

  // per-voice status codes
  typedef enum logic [1:0] {
    ST_FREE  = 2'd0,
    ST_PLAY  = 2'd1,
    ST_ALLOC = 2'd2,
    ST_EXT   = 2'd3
  } voice_state_e;

  // control sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_NOISE0,
    S_NOISE1,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_RMW_RD,
    S_RMW_WR,
    S_DONE
  } state_e;

  // request word
  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [GROUP_W-1:0] group;
    logic [PRI_W-1:0]   priority_req;
    logic [VOICE_W-1:0] voice;
    logic [TICK_W-1:0]  current_tick;
  } req_t;

  // response word
  typedef struct packed {
    logic               granted;
    logic [VOICE_W-1:0] voice_out;
    logic               stolen;
    logic               noise_mode;
  } resp_t;

  // one entry of the voice state memory
  typedef struct packed {
    voice_state_e       status;
    logic [PRI_W-1:0]   pri;
    logic [TICK_W-1:0]  tick;
  } voice_entry_t;

  // read beat returning from the memory into the scan unit
  typedef struct packed {
    logic               vld;
    logic               first;
    logic [VOICE_W-1:0] idx;
  } scan_beat_t;

  // running result of a scan pass
  typedef struct packed {
    logic               free_found;
    logic [VOICE_W-1:0] free_idx;
    logic [VOICE_W-1:0] low_idx;
    logic [PRI_W-1:0]   low_pri;
    logic               low_ext;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== src/pva_voice_mem.sv =====
// voice state memory: one write port, one registered read port, per-entry valid bits
`timescale 1ns / 1ps
`default_nettype none

module pva_voice_mem #(
  parameter int unsigned DEPTH = 48,
  parameter int unsigned AW    = 6
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         we_i,
  input  wire  [AW-1:0]               waddr_i,
  input  wire  pva_pkg::voice_entry_t wdata_i,
  input  wire                         re_i,
  input  wire  [AW-1:0]               raddr_i,
  output pva_pkg::voice_entry_t       rdata_o
);

  pva_pkg::voice_entry_t mem [DEPTH];
  logic [DEPTH-1:0]      valid_q;
  pva_pkg::voice_entry_t rdata_q;
  logic                  rvalid_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // valid bits stand in for the all-zero reset contents
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  // unwritten entries read as free, priority 0, tick 0
  assign rdata_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ===== src/pva_scan.sv =====
// scan unit: tracks first free voice and steal victim over one pass of reads
`timescale 1ns / 1ps
`default_nettype none

module pva_scan (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire  pva_pkg::scan_beat_t   beat_i,
  input  wire  pva_pkg::voice_entry_t entry_i,
  output pva_pkg::scan_res_t          res_o
);

  pva_pkg::scan_res_t res_q;
  logic [pva_pkg::TICK_W-1:0] low_tick_q;
  logic is_free;
  logic is_lower;

  assign is_free  = (entry_i.status == pva_pkg::ST_FREE);
  // strictly lower priority, or equal priority and older, and not external
  assign is_lower = (entry_i.status != pva_pkg::ST_EXT) &&
                    ((entry_i.pri < res_q.low_pri) ||
                     ((entry_i.pri == res_q.low_pri) && (entry_i.tick < low_tick_q)));

  // running free search and victim compare
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q      <= '0;
      low_tick_q <= '0;
    end else if (beat_i.vld) begin
      if (beat_i.first) begin
        res_q.free_found <= is_free;
        res_q.free_idx   <= beat_i.idx;
        res_q.low_idx    <= beat_i.idx;
        res_q.low_pri    <= entry_i.pri;
        res_q.low_ext    <= (entry_i.status == pva_pkg::ST_EXT);
        low_tick_q       <= entry_i.tick;
      end else begin
        if (!res_q.free_found && is_free) begin
          res_q.free_found <= 1'b1;
          res_q.free_idx   <= beat_i.idx;
        end
        if (is_lower) begin
          res_q.low_idx <= beat_i.idx;
          res_q.low_pri <= entry_i.pri;
          res_q.low_ext <= 1'b0;
          low_tick_q    <= entry_i.tick;
        end
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// ===== src/priority_voice_allocator.sv =====
// top level: request sequencer, range registers, noise owners, output register
`timescale 1ns / 1ps
`default_nettype none

// Priority voice allocator. One request word is handled at a time. The voice
// state (status, priority, start tick) sits in a single-port-read memory, so an
// allocation walks its group's voice range one entry per cycle, finding the
// first free voice and the steal victim in the same pass. A pass ends with the
// drain and decide states, and the result then goes to the output register. A
// noise allocate considers the lower core first and makes a pass over the upper
// core's voices when the lower core gives no voice. Free or mark playing reads
// the entry, modifies its status and writes it back. A new request is taken
// while the previous response waits in the output register.
// Range registers are written through the config port, which is always ready.
module priority_voice_allocator #(
  parameter int unsigned NUM_VOICES_TOTAL = 48,
  parameter int unsigned VOICES_PER_CORE  = 24,
  parameter int unsigned NUM_GROUPS       = 16
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_ready_o,
  input  wire  pva_pkg::req_t              in_data_i,
  output logic                             out_valid_o,
  input  wire                              out_ready_i,
  output pva_pkg::resp_t                   out_data_o,
  input  wire                              cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire  [pva_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [pva_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int unsigned AW = $clog2(NUM_VOICES_TOTAL);
  localparam int unsigned VW = pva_pkg::VOICE_W;
  localparam int unsigned PW = pva_pkg::PRI_W;

  // configuration registers
  logic [pva_pkg::CFG_W-1:0] range_q [pva_pkg::NUM_CFG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(pva_pkg::NUM_CFG); i++) begin
        range_q[i] <= pva_pkg::RANGE_RESET;
      end
    end else if (cfg_valid_i) begin
      range_q[cfg_index_i] <= cfg_data_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // group range decode from the incoming word
  logic [pva_pkg::GROUP_W-1:0]     grp;
  logic [pva_pkg::CFG_W-1:0]       grp_word;
  logic [pva_pkg::RANGE_FLD_W-1:0] grp_fld;
  logic [VW-1:0]                   in_lo;
  logic [VW-1:0]                   in_hi_raw;
  logic [VW-1:0]                   in_hi;

  assign grp = ({1'b0, in_data_i.group} >= 5'(NUM_GROUPS)) ?
               4'(NUM_GROUPS - 1) : in_data_i.group;
  assign grp_word = range_q[grp[3:2]];

  always_comb begin
    case (grp[1:0])
      2'd0:    grp_fld = grp_word[11:0];
      2'd1:    grp_fld = grp_word[23:12];
      2'd2:    grp_fld = grp_word[35:24];
      default: grp_fld = grp_word[47:36];
    endcase
  end

  assign in_lo     = grp_fld[5:0];
  assign in_hi_raw = grp_fld[11:6];
  assign in_hi     = ({1'b0, in_hi_raw} >= 7'(NUM_VOICES_TOTAL)) ?
                     6'(NUM_VOICES_TOTAL - 1) : in_hi_raw;

  // sequencer and request registers
  pva_pkg::state_e state_q, state_d;
  logic [pva_pkg::FUNC_W-1:0] func_q;
  logic [PW-1:0]              pri_q;
  logic [VW-1:0]              voice_q;
  logic [pva_pkg::TICK_W-1:0] tick_q;
  logic [VW-1:0]              lo_q;
  logic [VW-1:0]              hi_q;
  logic [VW-1:0]              cur_q;
  logic [VW-1:0]              end_q;
  logic                       first_q;
  logic                       core_q;
  pva_pkg::scan_beat_t        beat_q;
  pva_pkg::resp_t             res_q;
  pva_pkg::resp_t             out_q;
  logic                       out_valid_q;

  // noise owners, one per core
  logic [1:0]    nv_q;
  logic [PW-1:0] npri_q  [2];
  logic [VW-1:0] nvoice_q[2];

  // memory and scan unit
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  pva_pkg::voice_entry_t mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  pva_pkg::voice_entry_t mem_rdata;
  pva_pkg::scan_res_t    scan_res;

  pva_voice_mem #(
    .DEPTH (NUM_VOICES_TOTAL),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pva_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat_q),
    .entry_i (mem_rdata),
    .res_o   (scan_res)
  );

  // request decode
  logic in_fire;
  logic is_noise;
  logic in_voice_ok;
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_noise    = (func_q == pva_pkg::FUNC_ALLOC_NOISE);
  assign in_voice_ok = ({1'b0, in_data_i.voice} < 7'(NUM_VOICES_TOTAL));

  // noise attempt bounds for the lower and upper core
  logic          try0;
  logic          try1;
  logic [VW-1:0] hi0;
  logic [VW-1:0] lo1;
  assign hi0  = ({1'b0, hi_q} >= 7'(VOICES_PER_CORE)) ? 6'(VOICES_PER_CORE - 1) : hi_q;
  assign lo1  = ({1'b0, lo_q} < 7'(VOICES_PER_CORE)) ? 6'(VOICES_PER_CORE) : lo_q;
  assign try0 = (!nv_q[0] || (npri_q[0] < pri_q)) &&
                ({1'b0, lo_q} < 7'(VOICES_PER_CORE)) && (lo_q <= hi0);
  assign try1 = (!nv_q[1] || (npri_q[1] < pri_q)) &&
                ({1'b0, hi_q} >= 7'(VOICES_PER_CORE)) && (lo1 <= hi_q);

  // outcome of a finished pass
  logic          steal_ok;
  logic          pass_ok;
  logic [VW-1:0] got_voice;
  assign steal_ok  = !((pri_q < scan_res.low_pri) ||
                       (scan_res.low_pri >= pva_pkg::PRIO_LOCKED) || scan_res.low_ext);
  assign pass_ok   = scan_res.free_found || steal_ok;
  assign got_voice = scan_res.free_found ? scan_res.free_idx : scan_res.low_idx;

  // noise owner release when a voice is freed or stolen
  logic          clr_en;
  logic [VW-1:0] clr_voice;
  logic          clr_hit0;
  logic          clr_hit1;
  assign clr_hit0 = clr_en && nv_q[0] && (nvoice_q[0] == clr_voice) &&
                    ({1'b0, clr_voice} < 7'(VOICES_PER_CORE));
  assign clr_hit1 = clr_en && nv_q[1] && (nvoice_q[1] == clr_voice) &&
                    ({1'b0, clr_voice} >= 7'(VOICES_PER_CORE)) &&
                    ({1'b0, clr_voice} < 7'(2 * VOICES_PER_CORE));

  logic out_load;
  assign out_load = (state_q == pva_pkg::S_DONE) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      pva_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_data_i.func)
            pva_pkg::FUNC_ALLOC, pva_pkg::FUNC_ALLOC_EXT: begin
              state_d = (in_lo <= in_hi) ? pva_pkg::S_SCAN : pva_pkg::S_DONE;
            end
            pva_pkg::FUNC_ALLOC_NOISE: state_d = pva_pkg::S_NOISE0;
            pva_pkg::FUNC_FREE, pva_pkg::FUNC_PLAY: begin
              state_d = in_voice_ok ? pva_pkg::S_RMW_RD : pva_pkg::S_DONE;
            end
            default: state_d = pva_pkg::S_DONE;
          endcase
        end
      end
      pva_pkg::S_NOISE0: state_d = try0 ? pva_pkg::S_SCAN : pva_pkg::S_NOISE1;
      pva_pkg::S_NOISE1: state_d = try1 ? pva_pkg::S_SCAN : pva_pkg::S_DONE;
      pva_pkg::S_SCAN:   state_d = (cur_q == end_q) ? pva_pkg::S_DRAIN : pva_pkg::S_SCAN;
      pva_pkg::S_DRAIN:  state_d = pva_pkg::S_DECIDE;
      pva_pkg::S_DECIDE: begin
        if (!pass_ok && is_noise && !core_q) begin
          state_d = pva_pkg::S_NOISE1;
        end else begin
          state_d = pva_pkg::S_DONE;
        end
      end
      pva_pkg::S_RMW_RD: state_d = pva_pkg::S_RMW_WR;
      pva_pkg::S_RMW_WR: state_d = pva_pkg::S_DONE;
      pva_pkg::S_DONE:   state_d = out_load ? pva_pkg::S_IDLE : pva_pkg::S_DONE;
      default:           state_d = pva_pkg::S_IDLE;
    endcase
  end

  // memory and owner control per state
  always_comb begin
    in_ready_o = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = cur_q[AW-1:0];
    mem_we     = 1'b0;
    mem_waddr  = got_voice[AW-1:0];
    mem_wdata  = '0;
    clr_en     = 1'b0;
    clr_voice  = scan_res.low_idx;
    case (state_q)
      pva_pkg::S_IDLE: in_ready_o = 1'b1;
      pva_pkg::S_SCAN: mem_re = 1'b1;
      pva_pkg::S_DECIDE: begin
        mem_we           = pass_ok;
        mem_wdata.status = (func_q == pva_pkg::FUNC_ALLOC_EXT) ?
                           pva_pkg::ST_EXT : pva_pkg::ST_ALLOC;
        mem_wdata.pri    = pri_q;
        mem_wdata.tick   = tick_q;
        clr_en           = !scan_res.free_found && steal_ok;
      end
      pva_pkg::S_RMW_RD: begin
        mem_re    = 1'b1;
        mem_raddr = voice_q[AW-1:0];
      end
      pva_pkg::S_RMW_WR: begin
        mem_we           = 1'b1;
        mem_waddr        = voice_q[AW-1:0];
        mem_wdata        = mem_rdata;
        mem_wdata.status = (func_q == pva_pkg::FUNC_FREE) ?
                           pva_pkg::ST_FREE : pva_pkg::ST_PLAY;
        clr_en           = (func_q == pva_pkg::FUNC_FREE);
        clr_voice        = voice_q;
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pva_pkg::S_IDLE;
      beat_q      <= '0;
      first_q     <= 1'b0;
      out_valid_q <= 1'b0;
      nv_q        <= '0;
      npri_q[0]   <= '0;
      npri_q[1]   <= '0;
      nvoice_q[0] <= '0;
      nvoice_q[1] <= '0;
    end else begin
      state_q      <= state_d;
      beat_q.vld   <= (state_q == pva_pkg::S_SCAN);
      beat_q.first <= first_q;
      beat_q.idx   <= cur_q;
      if (state_q == pva_pkg::S_SCAN) begin
        first_q <= 1'b0;
      end else if (state_d == pva_pkg::S_SCAN) begin
        first_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // release the owner of a freed or stolen voice
      if (clr_hit0) begin
        nv_q[0]     <= 1'b0;
        npri_q[0]   <= '0;
        nvoice_q[0] <= '0;
      end
      if (clr_hit1) begin
        nv_q[1]     <= 1'b0;
        npri_q[1]   <= '0;
        nvoice_q[1] <= '0;
      end
      // claim the owner slot on a granted noise request
      if ((state_q == pva_pkg::S_DECIDE) && pass_ok && is_noise) begin
        nv_q[core_q]     <= 1'b1;
        npri_q[core_q]   <= pri_q;
        nvoice_q[core_q] <= got_voice;
      end
    end
  end

  // request, scan bound and result registers
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
    case (state_q)
      pva_pkg::S_IDLE: begin
        if (in_fire) begin
          func_q  <= in_data_i.func;
          pri_q   <= in_data_i.priority_req;
          voice_q <= in_data_i.voice;
          tick_q  <= in_data_i.current_tick;
          lo_q    <= in_lo;
          hi_q    <= in_hi;
          cur_q   <= in_lo;
          end_q   <= in_hi;
          core_q  <= 1'b0;
          res_q   <= '0;
        end
      end
      pva_pkg::S_NOISE0: begin
        cur_q  <= lo_q;
        end_q  <= hi0;
        core_q <= 1'b0;
      end
      pva_pkg::S_NOISE1: begin
        cur_q  <= lo1;
        end_q  <= hi_q;
        core_q <= 1'b1;
      end
      pva_pkg::S_SCAN: begin
        if (cur_q != end_q) begin
          cur_q <= cur_q + 6'd1;
        end
      end
      pva_pkg::S_DECIDE: begin
        if (pass_ok) begin
          res_q.granted    <= 1'b1;
          res_q.voice_out  <= got_voice;
          res_q.stolen     <= !scan_res.free_found;
          res_q.noise_mode <= is_noise;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // a steal always comes with a grant
  a_stolen_granted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.stolen |-> out_data_o.granted)
    else $error("stolen word without grant");

  // granted voice lies inside the voice array
  a_voice_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.granted |-> ({1'b0, out_data_o.voice_out} <
                                           7'(NUM_VOICES_TOTAL)))
    else $error("granted voice out of range");

  // the scan cursor never runs past the range end
  a_scan_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pva_pkg::S_SCAN) |-> (cur_q <= end_q))
    else $error("scan cursor past range end");

  // memory is never read and written in the same cycle
  a_no_rw_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("voice memory read and write overlap");

  // the lower noise owner, once claimed, points at a voice of its own core
  a_owner_core : assert property (@(posedge clk_i) disable iff (!rst_ni)
    nv_q[0] |-> ({1'b0, nvoice_q[0]} < 7'(VOICES_PER_CORE)))
    else $error("lower noise owner outside its core");
`endif

endmodule

`default_nettype wire
